[hw/rtl/rid_pkg.sv]
package rid_pkg;

    // Defaults for the top-level parameters.
    localparam int SAMPLES_DEF      = 64;
    localparam int TWIDDLE_BITS_DEF = 16;

    // Fixed field and datapath widths.
    localparam int SAMPLE_W = 8;
    localparam int ACC_W    = 32;
    localparam int PART_W   = 18;
    localparam int BIN_W    = 6;

    // Output saturation limits, as magnitudes.
    localparam int PART_POS_LIM = 131071;
    localparam int PART_NEG_LIM = 131072;

    localparam logic signed [PART_W-1:0] PART_MAX_VAL = 18'sd131071;
    localparam logic signed [PART_W-1:0] PART_MIN_VAL = -18'sd131072;

    // Register stages of the output scaler.
    localparam int SCALE_STAGES = 4;

    // Q30 constants for building the twiddle tables.
    localparam longint Q30_ONE     = 64'sd1073741824;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    // Taylor series term divisors (n+1)*(n+2) for sine and cosine.
    localparam longint SIN_DIV [14] = '{
        64'sd6,   64'sd20,  64'sd42,  64'sd72,  64'sd110, 64'sd156, 64'sd210,
        64'sd272, 64'sd342, 64'sd420, 64'sd506, 64'sd600, 64'sd702, 64'sd812
    };
    localparam longint COS_DIV [14] = '{
        64'sd2,   64'sd12,  64'sd30,  64'sd56,  64'sd90,  64'sd132, 64'sd182,
        64'sd240, 64'sd306, 64'sd380, 64'sd462, 64'sd552, 64'sd650, 64'sd756
    };

    // One sample moving down the row of bin cells.
    typedef struct packed {
        logic                valid;
        logic                last;
        logic [SAMPLE_W-1:0] sample;
    } rid_tok_t;

    // Control that travels alongside the scaler pipeline.
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [BIN_W-1:0] bin;
    } rid_meta_t;

    // Integer Taylor series in Q30 for an angle in the first quadrant.
    function automatic longint taylor_q30(input longint phi, input longint first,
                                          input logic is_cos);
        longint x2;
        longint term;
        longint sum;
        x2   = (phi * phi) >>> 30;
        term = first;
        sum  = first;
        for (int i = 0; i < 14; i++) begin
            term = (term * x2) >>> 30;
            if (is_cos) begin
                term = term / COS_DIV[i];
            end
            else begin
                term = term / SIN_DIV[i];
            end
            if (i[0]) begin
                sum = sum + term;
            end
            else begin
                sum = sum - term;
            end
        end
        return sum;
    endfunction

    // Converts a Q30 value to a twiddle with tb bits, rounding half away
    // from zero and saturating the magnitude at the largest positive value.
    function automatic longint to_twiddle(input longint v, input int tb);
        longint mag;
        longint maxv;
        int     sh;
        sh   = 31 - tb;
        maxv = (longint'(1) << (tb - 1)) - 1;
        mag  = (v < 0) ? -v : v;
        mag  = (mag + (longint'(1) << (sh - 1))) >>> sh;
        if (mag > maxv) begin
            mag = maxv;
        end
        return (v < 0) ? -mag : mag;
    endfunction

endpackage

[hw/rtl/rid_cell.sv]
module rid_cell
    import rid_pkg::*;
#(
    parameter int SAMPLES      = SAMPLES_DEF,
    parameter int TWIDDLE_BITS = TWIDDLE_BITS_DEF,
    parameter int BIN          = 0
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  rid_tok_t                       tok_i,
    output rid_tok_t                       tok_o,
    input  logic                           shift_en,
    input  logic signed [TWIDDLE_BITS-1:0] cos_rom [SAMPLES],
    input  logic signed [TWIDDLE_BITS-1:0] sin_rom [SAMPLES],
    input  logic signed [ACC_W-1:0]        real_i,
    input  logic signed [ACC_W-1:0]        imag_i,
    output logic signed [ACC_W-1:0]        real_o,
    output logic signed [ACC_W-1:0]        imag_o
);

    localparam int PW = $clog2(SAMPLES);

    rid_tok_t                              tok_reg;
    logic [PW-1:0]                         phase_reg;
    logic [PW-1:0]                         phase_next;
    logic [PW:0]                           phase_sum;
    logic signed [ACC_W-1:0]               real_reg;
    logic signed [ACC_W-1:0]               real_next;
    logic signed [ACC_W-1:0]               imag_reg;
    logic signed [ACC_W-1:0]               imag_next;
    logic signed [TWIDDLE_BITS-1:0]        cos_w;
    logic signed [TWIDDLE_BITS-1:0]        sin_w;
    logic signed [TWIDDLE_BITS+SAMPLE_W:0] prod_re;
    logic signed [TWIDDLE_BITS+SAMPLE_W:0] prod_im;

    // The phase of this bin steps by the bin number for every sample and
    // comes back to zero after a whole frame.
    always_comb
    begin
        phase_sum = {1'b0, phase_reg} + (PW + 1)'(BIN);
        if (phase_sum >= (PW + 1)'(SAMPLES)) begin
            phase_sum = phase_sum - (PW + 1)'(SAMPLES);
        end
        phase_next = phase_sum[PW-1:0];
    end

    assign cos_w   = cos_rom[phase_reg];
    assign sin_w   = sin_rom[phase_reg];
    assign prod_re = $signed({1'b0, tok_i.sample}) * cos_w;
    assign prod_im = $signed({1'b0, tok_i.sample}) * sin_w;

    always_comb
    begin
        real_next = real_reg;
        imag_next = imag_reg;
        if (shift_en) begin
            real_next = real_i;
            imag_next = imag_i;
        end
        else if (tok_i.valid) begin
            real_next = real_reg + ACC_W'(prod_re);
            imag_next = imag_reg - ACC_W'(prod_im);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            tok_reg   <= '0;
            phase_reg <= '0;
            real_reg  <= '0;
            imag_reg  <= '0;
        end
        else begin
            tok_reg  <= tok_i;
            real_reg <= real_next;
            imag_reg <= imag_next;
            if (tok_i.valid) begin
                phase_reg <= phase_next;
            end
        end
    end

    assign tok_o  = tok_reg;
    assign real_o = real_reg;
    assign imag_o = imag_reg;

endmodule

[hw/rtl/rid_scale.sv]
module rid_scale
    import rid_pkg::*;
#(
    parameter int SAMPLES      = SAMPLES_DEF,
    parameter int TWIDDLE_BITS = TWIDDLE_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [ACC_W-1:0]  acc,
    input  logic                     dbl,
    output logic signed [PART_W-1:0] part
);

    localparam int     NUM_W    = ACC_W + 10;
    localparam longint HALF_DIV = longint'(SAMPLES) << (TWIDDLE_BITS - 2);
    localparam longint CLAMP    = longint'(SAMPLES) * (PART_NEG_LIM + 1);
    localparam int     QW       = $clog2(CLAMP + 1);
    localparam int     LS       = $clog2(SAMPLES);
    localparam int     RW       = QW + 2;
    localparam longint RECIP    = ((longint'(1) << (QW + LS)) + SAMPLES - 1) / SAMPLES;
    localparam int     QFW      = RW - LS;

    logic                     neg1_reg;
    logic                     dbl1_reg;
    logic [ACC_W-1:0]         mag1_reg;
    logic [NUM_W-1:0]         num;
    logic [NUM_W-1:0]         rnd;
    logic [NUM_W-1:0]         q1;
    logic [QW-1:0]            q1c_next;
    logic [QW-1:0]            q1c_reg;
    logic                     neg2_reg;
    logic [QW+RW-1:0]         prod_reg;
    logic                     neg3_reg;
    logic [QFW-1:0]           quo;
    logic signed [PART_W-1:0] part_next;
    logic signed [PART_W-1:0] part_reg;

    // Stage 2: scale by 256 or 512, round, divide by the power of two in
    // the divisor and clamp anything that will saturate anyway.
    always_comb
    begin
        if (dbl1_reg) begin
            num = NUM_W'({mag1_reg, 9'b0});
        end
        else begin
            num = NUM_W'({mag1_reg, 8'b0});
        end
        rnd = num + NUM_W'(HALF_DIV);
        q1  = rnd >> (TWIDDLE_BITS - 1);
        if (q1 >= NUM_W'(CLAMP)) begin
            q1c_next = QW'(CLAMP);
        end
        else begin
            q1c_next = q1[QW-1:0];
        end
    end

    // Stage 4: the reciprocal product gives the exact quotient by SAMPLES.
    assign quo = prod_reg[QW+RW-1:QW+LS];

    always_comb
    begin
        if (neg3_reg) begin
            if (quo > QFW'(PART_NEG_LIM)) begin
                part_next = PART_MIN_VAL;
            end
            else begin
                part_next = PART_W'(0) - quo[PART_W-1:0];
            end
        end
        else begin
            if (quo > QFW'(PART_POS_LIM)) begin
                part_next = PART_MAX_VAL;
            end
            else begin
                part_next = quo[PART_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            neg1_reg <= acc[ACC_W-1];
            dbl1_reg <= dbl;
            mag1_reg <= acc[ACC_W-1] ? (ACC_W'(0) - acc) : acc;
            q1c_reg  <= q1c_next;
            neg2_reg <= neg1_reg;
            prod_reg <= q1c_reg * RW'(RECIP);
            neg3_reg <= neg2_reg;
            part_reg <= part_next;
        end
    end

    assign part = part_reg;

endmodule

[hw/rtl/real_input_dft_core.sv]
// Throughput: one sample per cycle inside a frame; after the frame the row drains before
// coefficients leave, one per cycle while coef_ready allows, SAMPLES/2+1 of them.
// Sample intake resumes as soon as the last coefficient has entered the scaler pipeline.
// Reset (rst_n, asynchronous, active low) clears all accumulators, the sample counter,
// the control state and the output valid.
module real_input_dft_core
    import rid_pkg::*;
#(
    parameter int SAMPLES      = SAMPLES_DEF,
    parameter int TWIDDLE_BITS = TWIDDLE_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     smp_valid,
    output logic                     smp_ready,
    input  logic [SAMPLE_W-1:0]      sample,
    output logic                     coef_valid,
    input  logic                     coef_ready,
    output logic [BIN_W-1:0]         bin_index,
    output logic signed [PART_W-1:0] real_part,
    output logic signed [PART_W-1:0] imag_part,
    output logic                     last_bin
);

    // The transform is built as a row of SAMPLES/2+1 bin cells. Each cell owns
    // the real and imaginary accumulators of one frequency bin and a phase
    // register that tracks (k*t) mod SAMPLES. An accepted sample enters cell 0
    // and moves one cell further in every cycle, so each cell does one
    // multiply-accumulate per sample with its own twiddle lookup. Because
    // samples follow each other through the row without stalling, a new
    // sample transaction can be taken in every cycle of a frame.
    //
    // After the last sample of a frame intake stops; the row drains until that
    // sample has left the final cell. The accumulators then shift toward cell 0
    // one bin per output transaction, with zeros coming in at the far end. Bin 0
    // leaves first and after SAMPLES/2+1 shifts every accumulator is clear for
    // the next frame. The bins pass through a four-stage scaler that applies
    // 1/SAMPLES or 2/SAMPLES, rounds to 8 fractional bits and saturates.

    localparam int NUM_BINS = SAMPLES / 2 + 1;
    localparam int PW       = $clog2(SAMPLES);
    localparam int CW       = $clog2(NUM_BINS);

    localparam logic [1:0] ST_ACCUM  = 2'd0;
    localparam logic [1:0] ST_DRAIN  = 2'd1;
    localparam logic [1:0] ST_UNLOAD = 2'd2;

    logic [1:0]                     state_reg;
    logic [1:0]                     state_next;
    logic [PW-1:0]                  pos_reg;
    logic [PW-1:0]                  pos_next;
    logic [CW-1:0]                  bin_cnt_reg;
    logic [CW-1:0]                  bin_cnt_next;
    logic                           pos_last;
    logic                           bin_last;
    logic                           smp_fire;
    logic                           advance;
    logic                           shift_en;
    rid_meta_t                      meta_reg [SCALE_STAGES];
    rid_meta_t                      meta0_next;
    rid_tok_t                       tok [NUM_BINS+1];
    logic signed [ACC_W-1:0]        re_chain [NUM_BINS+1];
    logic signed [ACC_W-1:0]        im_chain [NUM_BINS+1];
    logic signed [TWIDDLE_BITS-1:0] cos_rom [SAMPLES];
    logic signed [TWIDDLE_BITS-1:0] sin_rom [SAMPLES];

    // Twiddle tables, worked out at elaboration from a Q30 Taylor series on
    // the first quadrant and folded into the other three by symmetry.
    for (genvar m = 0; m < SAMPLES; m++) begin : g_rom
        localparam longint Quad = (4 * m) / SAMPLES;
        localparam longint Rem  = (4 * m) % SAMPLES;
        localparam longint Phi  = (HALF_PI_Q30 * Rem + SAMPLES / 2) / SAMPLES;
        localparam longint SinV = taylor_q30(Phi, Phi, 1'b0);
        localparam longint CosV = taylor_q30(Phi, Q30_ONE, 1'b1);
        localparam longint CosQ = (Quad == 0) ? CosV : (Quad == 1) ? -SinV :
                                  (Quad == 2) ? -CosV : SinV;
        localparam longint SinQ = (Quad == 0) ? SinV : (Quad == 1) ? CosV :
                                  (Quad == 2) ? -SinV : -CosV;
        assign cos_rom[m] = $signed(TWIDDLE_BITS'(to_twiddle(CosQ, TWIDDLE_BITS)));
        assign sin_rom[m] = $signed(TWIDDLE_BITS'(to_twiddle(SinQ, TWIDDLE_BITS)));
    end

    // Input side. Samples are only taken while accumulating.
    assign smp_ready = (state_reg == ST_ACCUM);
    assign smp_fire  = smp_valid && smp_ready;
    assign pos_last  = (pos_reg == PW'(SAMPLES - 1));

    assign tok[0] = '{valid: smp_fire, last: pos_last, sample: sample};

    // The scaler pipeline moves as a whole whenever its output register is
    // free or being emptied.
    assign advance  = !meta_reg[SCALE_STAGES-1].valid || coef_ready;
    assign shift_en = (state_reg == ST_UNLOAD) && advance;
    assign bin_last = (bin_cnt_reg == CW'(NUM_BINS - 1));

    // Nothing enters behind the last bin during an unload.
    assign re_chain[NUM_BINS] = '0;
    assign im_chain[NUM_BINS] = '0;

    for (genvar k = 0; k < NUM_BINS; k++) begin : g_cell
        rid_cell #(
            .SAMPLES      (SAMPLES),
            .TWIDDLE_BITS (TWIDDLE_BITS),
            .BIN          (k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .tok_i    (tok[k]),
            .tok_o    (tok[k+1]),
            .shift_en (shift_en),
            .cos_rom  (cos_rom),
            .sin_rom  (sin_rom),
            .real_i   (re_chain[k+1]),
            .imag_i   (im_chain[k+1]),
            .real_o   (re_chain[k]),
            .imag_o   (im_chain[k])
        );
    end

    // Frame sequencing. The drain ends when the final sample of the frame
    // shows up at the output of the last cell, which means every bin has it.
    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        bin_cnt_next = bin_cnt_reg;
        unique case (state_reg)
            ST_ACCUM:
            begin
                if (smp_fire) begin
                    if (pos_last) begin
                        pos_next   = '0;
                        state_next = ST_DRAIN;
                    end
                    else begin
                        pos_next = pos_reg + PW'(1);
                    end
                end
            end
            ST_DRAIN:
            begin
                if (tok[NUM_BINS].valid && tok[NUM_BINS].last) begin
                    state_next = ST_UNLOAD;
                end
            end
            ST_UNLOAD:
            begin
                if (advance) begin
                    if (bin_last) begin
                        bin_cnt_next = '0;
                        state_next   = ST_ACCUM;
                    end
                    else begin
                        bin_cnt_next = bin_cnt_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= ST_ACCUM;
            pos_reg     <= '0;
            bin_cnt_reg <= '0;
        end
        else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            bin_cnt_reg <= bin_cnt_next;
        end
    end

    // Bin number and end-of-frame flag ride alongside the scaler stages.
    always_comb
    begin
        meta0_next.valid = (state_reg == ST_UNLOAD);
        meta0_next.last  = bin_last;
        meta0_next.bin   = BIN_W'(bin_cnt_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < SCALE_STAGES; i++) begin
                meta_reg[i] <= '0;
            end
        end
        else if (advance) begin
            meta_reg[0] <= meta0_next;
            for (int i = 1; i < SCALE_STAGES; i++) begin
                meta_reg[i] <= meta_reg[i-1];
            end
        end
    end

    // Bin 0 is scaled by 1/SAMPLES, every other bin by 2/SAMPLES.
    rid_scale #(
        .SAMPLES      (SAMPLES),
        .TWIDDLE_BITS (TWIDDLE_BITS)
    ) u_scale_re (
        .clk  (clk),
        .en   (advance),
        .acc  (re_chain[0]),
        .dbl  (bin_cnt_reg != '0),
        .part (real_part)
    );

    rid_scale #(
        .SAMPLES      (SAMPLES),
        .TWIDDLE_BITS (TWIDDLE_BITS)
    ) u_scale_im (
        .clk  (clk),
        .en   (advance),
        .acc  (im_chain[0]),
        .dbl  (bin_cnt_reg != '0),
        .part (imag_part)
    );

    assign coef_valid = meta_reg[SCALE_STAGES-1].valid;
    assign bin_index  = meta_reg[SCALE_STAGES-1].bin;
    assign last_bin   = meta_reg[SCALE_STAGES-1].last;

endmodule
